// ===== rtl/core/xcr_pkg.sv =====
// xcr_pkg: types, codes and helper functions for the xmodem crc receiver
// no dependencies; imported by every module of the block
package xcr_pkg;

  // serial control characters
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [10:0] SHORT_PACKET_BYTES = 11'd128;
  localparam logic [10:0] LONG_PACKET_BYTES  = 11'd1024;
  localparam logic [15:0] CRC_POLY           = 16'h1021;
  localparam logic [7:0]  ERR_SAT            = 8'hFF;

  localparam logic [7:0]  MAX_ERRORS_RST  = 8'd3;
  localparam logic [31:0] FLASH_BASE_RST  = 32'h0800_8000;

  // most results one transaction can cause
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned SLOT_W  = $clog2(MAX_RES);

  typedef enum logic [2:0] {
    PH_END, PH_HEAD, PH_NUM, PH_CMP, PH_DATA, PH_CRCH, PH_CRCL, PH_FLASH
  } phase_e;

  typedef enum logic [1:0] {
    ACT_START, ACT_BYTE, ACT_TIMEOUT, ACT_FLASH
  } action_e;

  typedef enum logic [2:0] {
    K_TX, K_DATA, K_COMMIT, K_DISCARD, K_FINISH
  } kind_e;

  typedef enum logic [1:0] {
    ST_COMPLETE, ST_CANCELLED, ST_ABORTED, ST_NO_FIRST
  } status_e;

  typedef enum logic {
    CFG_MAX_ERRORS, CFG_FLASH_BASE
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  max_errors;
    logic [31:0] flash_base;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic [7:0]  data_byte;
    logic [9:0]  data_offset;
    logic [31:0] write_address;
    logic [10:0] byte_count;
    logic        erase_first;
    status_e     end_status;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    res_t [MAX_RES-1:0] slot;
  } res_bundle_t;

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic res_t tx_res(logic [7:0] c);
    res_t r;
    r = '0;
    r.kind = K_TX;
    r.tx_byte = c;
    return r;
  endfunction

  function automatic res_t fin_res(status_e s);
    res_t r;
    r = '0;
    r.kind = K_FINISH;
    r.end_status = s;
    return r;
  endfunction

  function automatic res_t discard_res();
    res_t r;
    r = '0;
    r.kind = K_DISCARD;
    return r;
  endfunction

  function automatic res_bundle_t push(res_bundle_t b, res_t r);
    res_bundle_t o;
    o = b;
    o.slot[b.count[SLOT_W-1:0]] = r;
    o.count = b.count + 1'b1;
    return o;
  endfunction

endpackage

// ===== rtl/core/xcr_if.sv =====
// xcr_if: valid/ready channel interfaces for the xmodem crc receiver
// input events, result items and configuration writes

interface xcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic       flash_good;

  modport source (output valid, action, rx_byte, flash_good, input ready);
  modport sink   (input valid, action, rx_byte, flash_good, output ready);
endinterface

interface xcr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  tx_byte;
  logic [7:0]  data_byte;
  logic [9:0]  data_offset;
  logic [31:0] write_address;
  logic [10:0] byte_count;
  logic        erase_first;
  logic [1:0]  end_status;
  logic        last;

  modport source (output valid, kind, tx_byte, data_byte, data_offset, write_address,
                  byte_count, erase_first, end_status, last, input ready);
  modport sink   (input valid, kind, tx_byte, data_byte, data_offset, write_address,
                  byte_count, erase_first, end_status, last, output ready);
endinterface

interface xcr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/xcr_cfg_regs.sv =====
// xcr_cfg_regs: configuration registers of the xmodem crc receiver
// depends on xcr_pkg and xcr_cfg_if
module xcr_cfg_regs import xcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  xcr_cfg_if.sink   cfg_if,
  output cfg_t      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      unique case (cfg_idx_e'(cfg_if.index))
        CFG_MAX_ERRORS: cfg_d.max_errors = cfg_if.data[7:0];
        CFG_FLASH_BASE: cfg_d.flash_base = cfg_if.data;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_errors <= MAX_ERRORS_RST;
      cfg_q.flash_base <= FLASH_BASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/xcr_engine.sv =====
// xcr_engine: input register, protocol state and per-event result decoding
// depends on xcr_pkg and xcr_in_if; feeds a bundle of results to xcr_res_buf
module xcr_engine import xcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  xcr_in_if.sink      in_if,
  input  cfg_t        cfg_i,
  input  logic        buf_free_i,
  output logic        load_o,
  output res_bundle_t bundle_o
);

  // input register
  logic       in_vld_q;
  action_e    act_q;
  logic [7:0] byte_q;
  logic       ok_q;
  logic       advance;

  // protocol state
  phase_e      phase_q, phase_d;
  logic [7:0]  exp_q, exp_d;
  logic [7:0]  gnum_q, gnum_d;
  logic [7:0]  gcmp_q, gcmp_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crch_q, crch_d;
  logic [10:0] idx_q, idx_d;
  logic        long_q, long_d;
  logic [7:0]  ec_q, ec_d;
  logic        first_q, first_d;
  logic [31:0] addr_q, addr_d;

  logic [10:0] pkt_size;
  logic [10:0] idx_inc;
  logic [7:0]  ec_inc;
  logic        err_abort;
  logic [8:0]  num_sum;
  logic        pkt_bad;
  res_bundle_t res;

  assign advance     = in_vld_q && buf_free_i;
  assign in_if.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      act_q  <= action_e'(in_if.action);
      byte_q <= in_if.rx_byte;
      ok_q   <= in_if.flash_good;
    end
  end

  assign pkt_size  = long_q ? LONG_PACKET_BYTES : SHORT_PACKET_BYTES;
  assign idx_inc   = idx_q + 11'd1;
  assign ec_inc    = (ec_q == ERR_SAT) ? ec_q : ec_q + 8'd1;
  assign err_abort = ec_inc >= cfg_i.max_errors;
  assign num_sum   = {1'b0, gnum_q} + {1'b0, gcmp_q};
  assign pkt_bad   = (gnum_q != exp_q) || (num_sum != 9'd255) ||
                     ({crch_q, byte_q} != crc_q);

  // nak, or can can and abort once the limit is hit
  function automatic res_bundle_t err_push(res_bundle_t b, logic abort);
    res_bundle_t o;
    o = b;
    if (abort) begin
      o = push(o, tx_res(CH_CAN));
      o = push(o, tx_res(CH_CAN));
      o = push(o, fin_res(ST_ABORTED));
    end else begin
      o = push(o, tx_res(CH_NAK));
    end
    return o;
  endfunction

  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    gnum_d  = gnum_q;
    gcmp_d  = gcmp_q;
    crc_d   = crc_q;
    crch_d  = crch_q;
    idx_d   = idx_q;
    long_d  = long_q;
    ec_d    = ec_q;
    first_d = first_q;
    addr_d  = addr_q;
    res     = '0;

    if (act_q == ACT_START) begin
      phase_d = PH_HEAD;
      exp_d   = 8'd1;
      gnum_d  = '0;
      gcmp_d  = '0;
      crc_d   = '0;
      crch_d  = '0;
      idx_d   = '0;
      long_d  = 1'b0;
      ec_d    = '0;
      first_d = 1'b0;
      addr_d  = cfg_i.flash_base;
      res     = push(res, tx_res(CH_C));
    end else if (phase_q != PH_END) begin
      case (act_q)
        ACT_TIMEOUT: begin
          if (phase_q == PH_FLASH) begin
            res = '0;
          end else if (phase_q == PH_HEAD && !first_q) begin
            ec_d = ec_inc;
            if (err_abort) begin
              res     = push(res, fin_res(ST_NO_FIRST));
              phase_d = PH_END;
            end else begin
              res = push(res, tx_res(CH_C));
            end
          end else begin
            // partial packet already handed out must be dropped
            if ((phase_q == PH_DATA && idx_q != '0) || phase_q == PH_CRCH ||
                phase_q == PH_CRCL) begin
              res = push(res, discard_res());
            end
            ec_d    = ec_inc;
            res     = err_push(res, err_abort);
            phase_d = err_abort ? PH_END : PH_HEAD;
          end
        end
        ACT_FLASH: begin
          if (phase_q == PH_FLASH) begin
            if (ok_q) begin
              first_d = 1'b1;
              exp_d   = exp_q + 8'd1;
              addr_d  = addr_q + {21'd0, pkt_size};
              ec_d    = '0;
              res     = push(res, tx_res(CH_ACK));
              phase_d = PH_HEAD;
            end else begin
              ec_d    = (cfg_i.max_errors == ERR_SAT) ? ERR_SAT : cfg_i.max_errors + 8'd1;
              res     = err_push(res, 1'b1);
              phase_d = PH_END;
            end
          end
        end
        ACT_BYTE: begin
          unique case (phase_q)
            PH_HEAD: begin
              if (byte_q == CH_SOH || byte_q == CH_STX) begin
                long_d  = (byte_q == CH_STX);
                idx_d   = '0;
                crc_d   = '0;
                phase_d = PH_NUM;
              end else if (byte_q == CH_EOT) begin
                res     = push(res, tx_res(CH_ACK));
                res     = push(res, fin_res(ST_COMPLETE));
                phase_d = PH_END;
              end else if (byte_q == CH_CAN) begin
                res     = push(res, fin_res(ST_CANCELLED));
                phase_d = PH_END;
              end else begin
                ec_d    = ec_inc;
                res     = err_push(res, err_abort);
                phase_d = err_abort ? PH_END : PH_HEAD;
              end
            end
            PH_NUM: begin
              gnum_d  = byte_q;
              phase_d = PH_CMP;
            end
            PH_CMP: begin
              gcmp_d  = byte_q;
              phase_d = PH_DATA;
            end
            PH_DATA: begin
              res.count               = CNT_W'(1);
              res.slot[0].kind        = K_DATA;
              res.slot[0].data_byte   = byte_q;
              res.slot[0].data_offset = idx_q[9:0];
              crc_d = crc_byte(crc_q, byte_q);
              idx_d = idx_inc;
              if (idx_inc >= pkt_size) begin
                phase_d = PH_CRCH;
              end
            end
            PH_CRCH: begin
              crch_d  = byte_q;
              phase_d = PH_CRCL;
            end
            PH_CRCL: begin
              if (gnum_q == exp_q - 8'd1) begin
                // repeat of the previous packet
                res     = push(res, discard_res());
                res     = push(res, tx_res(CH_ACK));
                ec_d    = '0;
                phase_d = PH_HEAD;
              end else if (pkt_bad) begin
                res     = push(res, discard_res());
                ec_d    = ec_inc;
                res     = err_push(res, err_abort);
                phase_d = err_abort ? PH_END : PH_HEAD;
              end else begin
                res.count                 = CNT_W'(1);
                res.slot[0].kind          = K_COMMIT;
                res.slot[0].write_address = addr_q;
                res.slot[0].byte_count    = pkt_size;
                res.slot[0].erase_first   = !first_q;
                phase_d = PH_FLASH;
              end
            end
            default: res = '0;
          endcase
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_END;
      exp_q   <= 8'd1;
      gnum_q  <= '0;
      gcmp_q  <= '0;
      crc_q   <= '0;
      crch_q  <= '0;
      idx_q   <= '0;
      long_q  <= 1'b0;
      ec_q    <= '0;
      first_q <= 1'b0;
      addr_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      gnum_q  <= gnum_d;
      gcmp_q  <= gcmp_d;
      crc_q   <= crc_d;
      crch_q  <= crch_d;
      idx_q   <= idx_d;
      long_q  <= long_d;
      ec_q    <= ec_d;
      first_q <= first_d;
      addr_q  <= addr_d;
    end
  end

  assign load_o   = advance;
  assign bundle_o = res;

  a_commit_waits_flash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.count != '0 && res.slot[0].kind == K_COMMIT) |=> phase_q == PH_FLASH)
    else $error("commit did not enter flash wait");

  a_ended_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == PH_END && act_q != ACT_START) |-> res.count == '0)
    else $error("result produced after transfer ended");

  a_data_index_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> idx_q < pkt_size)
    else $error("payload index past packet end");

endmodule

// ===== rtl/core/xcr_res_buf.sv =====
// xcr_res_buf: result register holding up to four results of one event
// depends on xcr_pkg and xcr_out_if; loaded by xcr_engine
module xcr_res_buf import xcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_bundle_t bundle_i,
  output logic        free_o,
  xcr_out_if.source   out_if
);

  res_t [MAX_RES-1:0] slot_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               pop;

  assign pop    = out_if.valid && out_if.ready;
  // the last pending result leaves this cycle, so a new set may land
  assign free_o = (cnt_q == '0) || (cnt_q == CNT_W'(1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
      slot_q[MAX_RES-1] <= '0;
    end
  end

  assign out_if.valid         = (cnt_q != '0);
  assign out_if.kind          = slot_q[0].kind;
  assign out_if.tx_byte       = slot_q[0].tx_byte;
  assign out_if.data_byte     = slot_q[0].data_byte;
  assign out_if.data_offset   = slot_q[0].data_offset;
  assign out_if.write_address = slot_q[0].write_address;
  assign out_if.byte_count    = slot_q[0].byte_count;
  assign out_if.erase_first   = slot_q[0].erase_first;
  assign out_if.end_status    = slot_q[0].end_status;
  assign out_if.last          = (cnt_q == CNT_W'(1));

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("results overwritten before delivery");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("delivered result not removed");

endmodule

// ===== rtl/core/xmodem_crc_receiver_top.sv =====
// xmodem_crc_receiver_top: xmodem-crc receiver, 128 and 1k packets
// depends on xcr_pkg, xcr_if, xcr_cfg_regs, xcr_engine, xcr_res_buf
//
//  channel  dir  payload
//  in_if    in   action, rx_byte, flash_good
//  out_if   out  kind, tx_byte, data_byte, data_offset, write_address,
//                byte_count, erase_first, end_status, last
//  cfg_if   in   index (0 max_errors, 1 flash_base_address), data
//
// an event is held in the input register, then is decoded in a single
// pass (crc byte update unrolled) into up to four results in the result
// register; results leave one per cycle while out_if is ready. a new event is
// taken while the last result of the previous one is being delivered. rst_ni
// clears the control state and leaves the transfer ended until a start event.
// cfg_if is always ready.
module xmodem_crc_receiver_top import xcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  xcr_in_if.sink      in_if,
  xcr_out_if.source   out_if,
  xcr_cfg_if.sink     cfg_if
);

  cfg_t        cfg;
  logic        buf_free;
  logic        load;
  res_bundle_t bundle;

  xcr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  xcr_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .cfg_i      (cfg),
    .buf_free_i (buf_free),
    .load_o     (load),
    .bundle_o   (bundle)
  );

  xcr_res_buf u_res_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .bundle_i (bundle),
    .free_o   (buf_free),
    .out_if   (out_if)
  );

endmodule
